@@ design/prq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned IdW           = 8;
  localparam int unsigned PrioW         = 8;

  localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
  localparam logic [1:0] CMD_PUT_BACK = 2'd1;
  localparam logic [1:0] CMD_TAKE     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   take;
    logic   sorted;
    entry_t item;
  } ctl_t;

endpackage

`default_nettype wire

@@ design/prq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module prq_cell
  import prq_pkg::*;
(
  input  wire logic   clk_i,
  input  wire ctl_t   ctl_i,
  input  wire logic   valid_i,
  input  wire logic   left_found_i,
  input  wire entry_t left_entry_i,
  input  wire entry_t right_entry_i,
  output      logic   found_o,
  output      entry_t entry_o
);

  entry_t entry_q;
  entry_t entry_d;
  logic   hit;

  // first free or first strictly later slot takes the new task; on put back the head slot takes it
  assign hit     = !valid_i || !ctl_i.sorted || (entry_q.prio > ctl_i.item.prio);
  assign found_o = left_found_i || hit;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.take) begin
      entry_d = right_entry_i;
    end else if (ctl_i.ins) begin
      if (left_found_i) begin
        entry_d = left_entry_i;
      end else if (hit) begin
        entry_d = ctl_i.item;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ design/priority_ready_queue.sv @@
// priority_ready_queue: sorted ready queue of tasks, smaller priority is more urgent
//
// command channel: a command transfers at a rising edge with start_i high and
// busy_o low; busy_o stays low, so one command can be given every cycle
// enqueue (0) inserts behind all tasks of equal or smaller priority number,
// put back (1) inserts at the head, take (2) removes the head task
// result channel: exactly one result per command, on out_task_id_o,
// out_priority_o and status_o while done_o is high, in the cycle after the command
// throughput 1 command per cycle; the row of cells compares all entries against
// the new priority in parallel and shifts the entries
// status: 0 ok, 1 queue full and task dropped, 2 queue empty on take
// task fields read zero unless a task was taken
// the receiver cannot stall: each result is shown for one cycle only
// reset empties the queue; entry contents are not cleared, only the count
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output      logic             busy_o,
  input  wire logic [1:0]       command_i,
  input  wire logic [IdW-1:0]   task_id_i,
  input  wire logic [PrioW-1:0] task_priority_i,
  output      logic             done_o,
  output      logic [IdW-1:0]   out_task_id_o,
  output      logic [PrioW-1:0] out_priority_o,
  output      logic [1:0]       status_o
);

  localparam int unsigned OccW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [OccW-1:0] OccFull = OccW'(QUEUE_DEPTH);

  logic [OccW-1:0]  occ_q, occ_d;
  logic             done_q;
  logic [IdW-1:0]   id_q, id_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic [1:0]       status_q, status_d;

  ctl_t   ctl;
  logic   is_full, is_empty;
  logic   found  [QUEUE_DEPTH];
  entry_t entries[QUEUE_DEPTH];

  assign is_full  = (occ_q == OccFull);
  assign is_empty = (occ_q == '0);
  assign busy_o   = 1'b0;

  always_comb begin
    ctl.ins         = 1'b0;
    ctl.take        = 1'b0;
    ctl.sorted      = (command_i == CMD_ENQUEUE);
    ctl.item.id     = task_id_i;
    ctl.item.prio   = task_priority_i;
    occ_d           = occ_q;
    id_d            = '0;
    prio_d          = '0;
    status_d        = ST_OK;
    if (start_i) begin
      unique case (command_i)
        CMD_ENQUEUE, CMD_PUT_BACK: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            occ_d   = occ_q + OccW'(1);
          end
        end
        CMD_TAKE: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctl.take = 1'b1;
            occ_d    = occ_q - OccW'(1);
            id_d     = entries[0].id;
            prio_d   = entries[0].prio;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic   left_found;
    entry_t left_entry;
    entry_t right_entry;

    if (k == 0) begin : g_head
      assign left_found = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_found = found[k-1];
      assign left_entry = entries[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entries[k+1];
    end

    prq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .valid_i       (occ_q > OccW'(k)),
      .left_found_i  (left_found),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .found_o       (found[k]),
      .entry_o       (entries[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      done_q   <= 1'b0;
      id_q     <= '0;
      prio_q   <= '0;
      status_q <= ST_OK;
    end else begin
      occ_q    <= occ_d;
      done_q   <= start_i;
      id_q     <= id_d;
      prio_q   <= prio_d;
      status_q <= status_d;
    end
  end

  assign done_o         = done_q;
  assign out_task_id_o  = id_q;
  assign out_priority_o = prio_q;
  assign status_o       = status_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccFull)
    else $error("occupancy above depth");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_q)
    else $error("command without result");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_FULL) |-> is_full)
    else $error("full drop changed occupancy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ST_EMPTY) |-> (id_q == '0 && prio_q == '0 && is_empty))
    else $error("empty take with task data");

endmodule

`default_nettype wire

@@ tb/priority_ready_queue_test.sv @@
`timescale 1ns / 1ps

module priority_ready_queue_test;
  import prq_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } sched_cmd_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
    logic [1:0]       status;
  } sched_result_t;

  typedef enum int {FILL_MODE, DRAIN_MODE, MIXED_MODE} traffic_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic [1:0]       command_i = CMD_TAKE;
  logic [IdW-1:0]   task_id_i = '0;
  logic [PrioW-1:0] task_priority_i = '0;
  logic             busy_o;
  logic             done_o;
  logic [IdW-1:0]   out_task_id_o;
  logic [PrioW-1:0] out_priority_o;
  logic [1:0]       status_o;

  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];
  entry_t        shadow_tasks[$];

  int fail_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int cmd_count[4] = '{0, 0, 0, 0};
  int full_drops = 0;
  int empty_takes = 0;
  int results_seen = 0;

  priority_ready_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .task_id_i      (task_id_i),
    .task_priority_i(task_priority_i),
    .done_o         (done_o),
    .out_task_id_o  (out_task_id_o),
    .out_priority_o (out_priority_o),
    .status_o       (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sorted insert with equal priorities kept in arrival order; put back inserts at the head, take pops the head
  function automatic sched_result_t apply_command(sched_cmd_t c);
    sched_result_t r;
    entry_t        e;
    int            pos;
    r = '0;
    r.status = ST_OK;
    e.id = c.id;
    e.prio = c.prio;
    case (c.command)
      CMD_ENQUEUE, CMD_PUT_BACK: begin
        if (shadow_tasks.size() >= DefQueueDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          if (c.command == CMD_ENQUEUE) begin
            while (pos < shadow_tasks.size() && shadow_tasks[pos].prio <= c.prio) pos++;
          end
          shadow_tasks.insert(pos, e);
        end
      end
      CMD_TAKE: begin
        if (shadow_tasks.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = shadow_tasks.pop_front();
          r.id = e.id;
          r.prio = e.prio;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_cmd(logic [1:0] command, logic [IdW-1:0] id, logic [PrioW-1:0] prio);
    sched_cmd_t c;
    c.command = command;
    c.id = id;
    c.prio = prio;
    pending_cmds.push_back(c);
  endtask

  // driver: bursts of transfers with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        sched_result_t r;
        r = apply_command(pending_cmds[0]);
        cmd_count[pending_cmds[0].command]++;
        if (r.status == ST_FULL) full_drops++;
        if (r.status == ST_EMPTY) empty_takes++;
        expected_results.push_back(r);
        void'(pending_cmds.pop_front());
      end
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          start_i <= 1'b1;
          command_i <= pending_cmds[0].command;
          task_id_i <= pending_cmds[0].id;
          task_priority_i <= pending_cmds[0].prio;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o cycle carries one result
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding: id %0d prio %0d status %0d",
               out_task_id_o, out_priority_o, status_o);
        fail_count++;
      end else begin
        sched_result_t r;
        r = expected_results.pop_front();
        if (out_task_id_o !== r.id) begin
          $error("out_task_id: expected %0d, actual %0d", r.id, out_task_id_o);
          fail_count++;
        end
        if (out_priority_o !== r.prio) begin
          $error("out_priority: expected %0d, actual %0d", r.prio, out_priority_o);
          fail_count++;
        end
        if (status_o !== r.status) begin
          $error("status: expected %0d, actual %0d", r.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int            n_items;
    int            seg_len;
    int            ins_pct;
    int            roll;
    traffic_mode_e mode;
    logic [1:0]       cmd;
    logic [PrioW-1:0] prio;

    // directed part
    add_cmd(CMD_TAKE, 8'h00, 8'h00);
    add_cmd(CMD_NONE, 8'hff, 8'hff);
    add_cmd(CMD_ENQUEUE, 8'hff, 8'hff);
    add_cmd(CMD_ENQUEUE, 8'h00, 8'h00);
    add_cmd(CMD_ENQUEUE, 8'h5a, 8'h80);
    add_cmd(CMD_ENQUEUE, 8'ha5, 8'h80);
    add_cmd(CMD_ENQUEUE, 8'h81, 8'h7f);
    add_cmd(CMD_PUT_BACK, 8'h3c, 8'hff);
    add_cmd(CMD_NONE, 8'h00, 8'h00);
    repeat (6) add_cmd(CMD_TAKE, 8'h00, 8'h00);
    add_cmd(CMD_TAKE, 8'hff, 8'hff);

    // random part: fill, drain and mixed stretches reach both full and empty
    n_items = 0;
    while (n_items < 400) begin
      mode = traffic_mode_e'($urandom_range(0, 2));
      seg_len = $urandom_range(8, 40);
      ins_pct = (mode == FILL_MODE) ? 80 : (mode == DRAIN_MODE) ? 20 : 50;
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_NONE;
        else if (roll < 3 + ins_pct * 97 / 100)
          cmd = ($urandom_range(0, 3) == 0) ? CMD_PUT_BACK : CMD_ENQUEUE;
        else cmd = CMD_TAKE;
        case ($urandom_range(0, 3))
          0: prio = PrioW'($urandom_range(0, 3));
          1: prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
          default: prio = PrioW'($urandom_range(0, 255));
        endcase
        add_cmd(cmd, IdW'($urandom_range(0, 255)), prio);
        if (cmd != CMD_NONE) n_items++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || start_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("commands: %0d enqueue, %0d put back, %0d take, %0d unused; %0d results checked",
             cmd_count[CMD_ENQUEUE], cmd_count[CMD_PUT_BACK], cmd_count[CMD_TAKE],
             cmd_count[CMD_NONE], results_seen);
    $display("queue full drops: %0d, takes from empty queue: %0d", full_drops, empty_takes);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
design/prq_pkg.sv
design/prq_cell.sv
design/priority_ready_queue.sv
tb/priority_ready_queue_test.sv
